[rtl/assert_macros.svh]
// assertion macros for the scheduler checks
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication, disabled in reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

[rtl/rrs_pkg.sv]
// shared types, codes and constants of the round-robin slice scheduler
// no dependencies; imported by every rtl module
`default_nettype none

package rrs_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int CD_W      = 20;
  localparam int MS_W      = 16;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_SLEEP = 3'd2;
  localparam logic [2:0] OP_EXIT  = 3'd3;
  localparam logic [2:0] OP_WAKE  = 3'd4;

  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_ACTIVE   = 2'd1;
  localparam logic [1:0] ST_SLEEPING = 2'd2;

  localparam logic [7:0] SLICE_RESET = 8'd10;

  typedef struct packed {
    logic [2:0]      op;
    logic [3:0]      slot;
    logic [MS_W-1:0] sleep_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  running_slot;
    logic        running_valid;
    logic        switched;
    logic [4:0]  woken_count;
    logic [31:0] switch_total;
    logic        error;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [1:0]        status;
    logic [CD_W-1:0]   countdown;
  } tbl_wr_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] push_slot;
  } fifo_ctl_t;

endpackage

`default_nettype wire

[rtl/rrs_slot_table.sv]
// per-slot status and wake countdown, one read and one write port
// depends on rrs_pkg
`default_nettype none

module rrs_slot_table
  import rrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SLOT_W-1:0] rd_addr,
  input  wire tbl_wr_t           wr,
  output logic [1:0]             rd_status,
  output logic [CD_W-1:0]        rd_countdown
);

  logic [1:0]      status    [NUM_SLOTS];
  logic [CD_W-1:0] countdown [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status[i] <= ST_FREE;
      end
    end else if (wr.en) begin
      status[wr.addr] <= wr.status;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      countdown[wr.addr] <= wr.countdown;
    end
  end

  assign rd_status    = status[rd_addr];
  assign rd_countdown = countdown[rd_addr];

endmodule

`default_nettype wire

[rtl/rrs_ready_fifo.sv]
// circular ready queue of slot numbers with head pointer and fill count
// depends on rrs_pkg
`default_nettype none

module rrs_ready_fifo
  import rrs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fifo_ctl_t         ctl,
  output logic [SLOT_W-1:0]      head_slot,
  output logic [CNT_W-1:0]       count
);

  logic [SLOT_W-1:0] order [NUM_SLOTS];
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic              push_ok;
  logic              pop_ok;

  assign tail    = head + count[SLOT_W-1:0];
  assign pop_ok  = ctl.pop && (count != '0);
  assign push_ok = ctl.push && (pop_ok || (count < CNT_W'(NUM_SLOTS)));

  always_ff @(posedge clk) begin
    if (push_ok) begin
      order[tail] <= ctl.push_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop_ok) begin
        head <= head + 1'b1;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head_slot = order[head];

endmodule

`default_nettype wire

[rtl/round_robin_slice_scheduler.sv]
// round-robin time-slice scheduler, one response per request
// a request is taken in IDLE and executed in EXEC; a tick then scans every slot in turn
// through the shared countdown unit in SCAN; the response is registered from DONE when free
// requests are taken only while idle, so a waiting response holds off the next one
// reset (rst, synchronous): all slots free, queue empty, idle, slice 10
// depends on rrs_pkg, rrs_slot_table, rrs_ready_fifo, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module round_robin_slice_scheduler
  import rrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_slice_length
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  logic [1:0]        state, state_next;
  req_t              cur, cur_next;
  logic [7:0]        slice_length;
  logic [7:0]        slice_used, slice_used_next;
  logic [SLOT_W-1:0] running_id, running_id_next;
  logic              running_flag, running_flag_next;
  logic [31:0]       switch_count, switch_count_next;
  logic [SLOT_W-1:0] scan_idx, scan_idx_next;
  logic [4:0]        woken, woken_next;
  logic              sw, sw_next;
  logic              err, err_next;

  logic [SLOT_W-1:0] rd_addr;
  logic [1:0]        rd_status;
  logic [CD_W-1:0]   rd_countdown;
  tbl_wr_t           tbl_wr;
  fifo_ctl_t         fifo_ctl;
  logic [SLOT_W-1:0] head_slot;
  logic [CNT_W-1:0]  fifo_count;

  logic              slot_ok;
  logic [CD_W-1:0]   sleep_ticks;
  logic [CD_W-1:0]   cd_dec;
  logic              do_dispatch;
  logic              requeue;
  logic [7:0]        su_inc;
  logic              rsp_load;

  rrs_slot_table u_table (
    .clk          (clk),
    .rst          (rst),
    .rd_addr      (rd_addr),
    .wr           (tbl_wr),
    .rd_status    (rd_status),
    .rd_countdown (rd_countdown)
  );

  rrs_ready_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .head_slot (head_slot),
    .count     (fifo_count)
  );

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);

  assign slot_ok     = (32'(cur.slot) < NUM_SLOTS);
  assign sleep_ticks = (CD_W'(cur.sleep_ms) << 3) + (CD_W'(cur.sleep_ms) << 1);
  assign su_inc      = (slice_used == 8'hFF) ? slice_used : slice_used + 8'd1;
  // shared countdown unit
  assign cd_dec      = (rd_countdown != '0) ? rd_countdown - 1'b1 : rd_countdown;

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    slice_used_next   = slice_used;
    running_id_next   = running_id;
    running_flag_next = running_flag;
    switch_count_next = switch_count;
    scan_idx_next     = scan_idx;
    woken_next        = woken;
    sw_next           = sw;
    err_next          = err;
    rd_addr           = cur.slot[SLOT_W-1:0];
    tbl_wr            = '0;
    fifo_ctl          = '0;
    do_dispatch       = 1'b0;
    requeue           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_next   = req;
          sw_next    = 1'b0;
          err_next   = 1'b0;
          woken_next = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        unique case (cur.op)
          OP_TICK: begin
            scan_idx_next = '0;
            state_next    = S_SCAN;
            if (running_flag) begin
              slice_used_next = su_inc;
              if (su_inc >= slice_length) begin
                do_dispatch = 1'b1;
                requeue     = 1'b1;
              end
            end else begin
              do_dispatch = 1'b1;
            end
          end
          OP_START: begin
            if (!slot_ok || rd_status != ST_FREE) begin
              err_next = 1'b1;
            end else begin
              tbl_wr.en          = 1'b1;
              tbl_wr.addr        = cur.slot[SLOT_W-1:0];
              tbl_wr.status      = ST_ACTIVE;
              fifo_ctl.push      = 1'b1;
              fifo_ctl.push_slot = cur.slot[SLOT_W-1:0];
            end
          end
          OP_SLEEP, OP_EXIT: begin
            if (!running_flag) begin
              err_next = 1'b1;
            end else begin
              tbl_wr.en         = 1'b1;
              tbl_wr.addr       = running_id;
              tbl_wr.status     = (cur.op == OP_SLEEP) ? ST_SLEEPING : ST_FREE;
              tbl_wr.countdown  = (cur.op == OP_SLEEP) ? sleep_ticks : '0;
              running_flag_next = 1'b0;
              do_dispatch       = 1'b1;
            end
          end
          OP_WAKE: begin
            if (!slot_ok || rd_status != ST_SLEEPING) begin
              err_next = 1'b1;
            end else begin
              tbl_wr.en          = 1'b1;
              tbl_wr.addr        = cur.slot[SLOT_W-1:0];
              tbl_wr.status      = ST_ACTIVE;
              fifo_ctl.push      = 1'b1;
              fifo_ctl.push_slot = cur.slot[SLOT_W-1:0];
            end
          end
          default: begin
            err_next = 1'b1;
          end
        endcase
        if (do_dispatch && fifo_count != '0) begin
          fifo_ctl.pop       = 1'b1;
          fifo_ctl.push      = requeue;
          fifo_ctl.push_slot = running_id;
          running_id_next    = head_slot;
          running_flag_next  = 1'b1;
          slice_used_next    = '0;
          switch_count_next  = switch_count + 32'd1;
          sw_next            = 1'b1;
        end
      end
      S_SCAN: begin
        rd_addr = scan_idx;
        if (rd_status == ST_SLEEPING) begin
          tbl_wr.en        = 1'b1;
          tbl_wr.addr      = scan_idx;
          tbl_wr.countdown = cd_dec;
          tbl_wr.status    = ST_SLEEPING;
          if (cd_dec == '0) begin
            tbl_wr.status      = ST_ACTIVE;
            fifo_ctl.push      = 1'b1;
            fifo_ctl.push_slot = scan_idx;
            woken_next         = woken + 5'd1;
          end
        end
        if (scan_idx == LAST_SLOT) begin
          state_next = S_DONE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slice_length <= SLICE_RESET;
      slice_used   <= '0;
      running_id   <= '0;
      running_flag <= 1'b0;
      switch_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      slice_used   <= slice_used_next;
      running_id   <= running_id_next;
      running_flag <= running_flag_next;
      switch_count <= switch_count_next;
      if (cfg_valid) begin
        slice_length <= cfg_slice_length;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    scan_idx <= scan_idx_next;
    woken    <= woken_next;
    sw       <= sw_next;
    err      <= err_next;
    if (rsp_load) begin
      rsp.running_slot  <= running_flag ? 4'(running_id) : 4'd0;
      rsp.running_valid <= running_flag;
      rsp.switched      <= sw;
      rsp.woken_count   <= woken;
      rsp.switch_total  <= switch_count;
      rsp.error         <= err;
    end
  end

  `CHK_IMPLY(a_queue_fits, clk, rst, 1'b1,
    (6'(fifo_count) + 6'(running_flag)) <= 6'(NUM_SLOTS))
  `CHK_IMPLY(a_switch_runs, clk, rst, rsp_valid, !rsp.switched || rsp.running_valid)
  `CHK_IMPLY(a_error_no_switch, clk, rst, rsp_valid, !(rsp.error && rsp.switched))
  `CHK_NEXT(a_scan_ends, clk, rst, state == S_SCAN && scan_idx == LAST_SLOT,
    state == S_DONE)

endmodule

`default_nettype wire
